// ===== design/rar3hc_pkg.sv =====
// ----------------------------------------------------------------------------
// rar3hc_pkg
// Shared constants and types for the RAR3 pre-code bit-length table check.
// ----------------------------------------------------------------------------
package rar3hc_pkg;

  localparam int TABLE_ENTRIES = 20;              // code lengths per table
  localparam int MAX_LEN       = 15;              // longest code length
  localparam int HDR_BITS      = 2;               // header bits dropped at block start
  localparam int IDX_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int CNT_W         = IDX_W;           // histogram bin width
  localparam int RUN_W         = IDX_W + 5;       // index plus longest zero run
  localparam int LVL_W         = 4;               // indexes the MAX_LEN bins
  localparam int REM_W         = 17;              // Kraft remainder, holds 2**MAX_LEN
  localparam int BUF_W         = 16;              // bit buffer
  localparam int BITS_W        = 4;               // bits held, at most 11

  localparam logic [3:0] NIB_ESC = 4'd15;         // escape nibble

  typedef enum logic [1:0] {
    VERDICT_VALID      = 2'd0,
    VERDICT_NONE       = 2'd1,
    VERDICT_OVER       = 2'd2,
    VERDICT_INCOMPLETE = 2'd3
  } verdict_t;

  typedef struct packed {
    logic start;   // begin a Kraft pass
    logic ack;     // verdict taken
  } kraft_ctl_t;

  typedef struct packed {
    logic             done;
    verdict_t         verdict;
    logic [LVL_W-1:0] level;   // histogram bin being read
  } kraft_sts_t;

endpackage

// ===== design/rar3hc_kraft.sv =====
// ----------------------------------------------------------------------------
// rar3hc_kraft
// Kraft check: one shift, compare and subtract per histogram bin.
// ----------------------------------------------------------------------------
module rar3hc_kraft import rar3hc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  kraft_ctl_t       ctl,
  input  logic [CNT_W-1:0] level_count,
  output kraft_sts_t       sts
);

  typedef enum logic [2:0] {
    K_IDLE = 3'b001,
    K_RUN  = 3'b010,
    K_DONE = 3'b100
  } kstate_t;

  kstate_t          state_r, state_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic             any_r, any_nxt;
  verdict_t         verdict_r, verdict_nxt;

  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] cnt_ext;
  logic [REM_W-1:0] diff;
  logic             any_now;

  always_comb begin
    shifted     = {rem_r[REM_W-2:0], 1'b0};
    cnt_ext     = REM_W'(level_count);
    diff        = shifted - cnt_ext;
    any_now     = any_r | (level_count != '0);
    state_nxt   = state_r;
    rem_nxt     = rem_r;
    lvl_nxt     = lvl_r;
    any_nxt     = any_r;
    verdict_nxt = verdict_r;
    case (state_r)
      K_IDLE: begin
        if (ctl.start) begin
          rem_nxt   = REM_W'(1);
          lvl_nxt   = '0;
          any_nxt   = 1'b0;
          state_nxt = K_RUN;
        end
      end
      K_RUN: begin
        if (shifted < cnt_ext) begin
          verdict_nxt = VERDICT_OVER;
          state_nxt   = K_DONE;
        end else begin
          rem_nxt = diff;
          any_nxt = any_now;
          if (lvl_r == LVL_W'(MAX_LEN - 1)) begin
            state_nxt = K_DONE;
            if (!any_now) begin
              verdict_nxt = VERDICT_NONE;
            end else if (diff != '0) begin
              verdict_nxt = VERDICT_INCOMPLETE;
            end else begin
              verdict_nxt = VERDICT_VALID;
            end
          end else begin
            lvl_nxt = lvl_r + LVL_W'(1);
          end
        end
      end
      K_DONE: begin
        if (ctl.ack) begin
          state_nxt = K_IDLE;
        end
      end
      default: begin
        state_nxt = K_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= K_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    lvl_r     <= lvl_nxt;
    any_r     <= any_nxt;
    verdict_r <= verdict_nxt;
  end

  assign sts.done    = (state_r == K_DONE);
  assign sts.verdict = verdict_r;
  assign sts.level   = lvl_r;

endmodule

// ===== design/rar3_huffman_table_check_core.sv =====
// ----------------------------------------------------------------------------
// rar3_huffman_table_check_core
// Screens a decrypted RAR3 block by checking its pre-code bit-length table.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one data byte per request, bits used
// MSB first; in_block_start marks the first byte of a block and clears the
// table state. Two header bits are dropped, then nibbles are decoded into
// code lengths, with escape nibble 15 followed by a count (0 = length 15,
// n = n+2 zero lengths, clipped at the end of the table).
// Output channel (out_valid/out_ready): one verdict per block, given on
// the request whose nibble fills the last entry; later bytes are dropped
// until the next block start.
// Timing: a byte is accepted in S_IDLE, then S_DECODE takes the one or two
// nibbles it yields, one per cycle; a dropped byte is only accepted. in_ready
// is high only while waiting for a byte.
// The closing Kraft pass reads one histogram bin per cycle through a
// single shift/compare/subtract unit, over at most 15 bins, then hands the
// verdict to the output register.
// Reset: idle, bytes without block start are ignored and give no verdict.
// A stalled receiver holds the verdict in the output register; a later
// verdict waits in the Kraft unit until the register frees up.
// ----------------------------------------------------------------------------
module rar3_huffman_table_check_core import rar3hc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_block_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_verdict
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,   // waiting for a byte
    S_DECODE = 3'b010,   // one nibble per cycle
    S_JUDGE  = 3'b100    // Kraft pass running
  } state_t;

  state_t            state_r, state_nxt;
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [BITS_W-1:0] bits_r, bits_nxt;
  logic              hdr_r, hdr_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              await_r, await_nxt;
  logic              done_r, done_nxt;
  logic              out_valid_r, out_valid_nxt;
  verdict_t          verdict_r, verdict_nxt;

  logic [CNT_W-1:0]  hist_r [MAX_LEN];

  logic              accept;
  logic              hist_clr;
  logic              inc_en;
  logic [3:0]        inc_len;
  logic [LVL_W-1:0]  inc_bin;
  logic [3:0]        nib;
  logic [BITS_W-1:0] bits_left;
  logic [BUF_W-1:0]  buf_eff;
  logic [BITS_W-1:0] bits_eff;
  logic              hdr_eff;
  logic              done_eff;
  logic [RUN_W-1:0]  run_end;
  logic              load_out;

  kraft_ctl_t        k_ctl;
  kraft_sts_t        k_sts;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign load_out = (state_r == S_JUDGE) && k_sts.done && (!out_valid_r || out_ready);

  // nibble extraction from the top of the held bits
  assign bits_left = bits_r - BITS_W'(4);
  assign nib       = 4'(buf_r >> bits_left);

  always_comb begin
    state_nxt   = state_r;
    buf_nxt     = buf_r;
    bits_nxt    = bits_r;
    hdr_nxt     = hdr_r;
    idx_nxt     = idx_r;
    await_nxt   = await_r;
    done_nxt    = done_r;
    hist_clr    = 1'b0;
    inc_en      = 1'b0;
    inc_len     = nib;
    run_end     = '0;
    k_ctl.start = 1'b0;
    k_ctl.ack   = load_out;
    buf_eff     = in_block_start ? '0 : buf_r;
    bits_eff    = in_block_start ? '0 : bits_r;
    hdr_eff     = in_block_start ? 1'b0 : hdr_r;
    done_eff    = in_block_start ? 1'b0 : done_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_block_start) begin
            hist_clr  = 1'b1;
            idx_nxt   = '0;
            await_nxt = 1'b0;
            done_nxt  = 1'b0;
            buf_nxt   = '0;
            bits_nxt  = '0;
            hdr_nxt   = 1'b0;
          end
          if (!done_eff) begin
            buf_nxt   = {buf_eff[BUF_W-9:0], in_data_byte};
            bits_nxt  = hdr_eff ? bits_eff + BITS_W'(8)
                                : bits_eff + BITS_W'(8) - BITS_W'(HDR_BITS);
            hdr_nxt   = 1'b1;
            state_nxt = S_DECODE;
          end
        end
      end
      S_DECODE: begin
        bits_nxt = bits_left;
        buf_nxt  = buf_r & ((BUF_W'(1) << bits_left) - BUF_W'(1));
        if (await_r) begin
          await_nxt = 1'b0;
          if (nib == 4'd0) begin
            inc_en  = 1'b1;
            inc_len = 4'(MAX_LEN);
            idx_nxt = idx_r + IDX_W'(1);
          end else begin
            run_end = RUN_W'(idx_r) + RUN_W'(nib) + RUN_W'(2);
            idx_nxt = (run_end > RUN_W'(TABLE_ENTRIES)) ? IDX_W'(TABLE_ENTRIES)
                                                        : IDX_W'(run_end);
          end
        end else if (nib == NIB_ESC) begin
          await_nxt = 1'b1;
        end else begin
          inc_en  = (nib != 4'd0);
          idx_nxt = idx_r + IDX_W'(1);
        end

        if (!await_nxt && (idx_nxt >= IDX_W'(TABLE_ENTRIES))) begin
          // table full: drop leftover bits, hand over to the Kraft unit
          done_nxt    = 1'b1;
          buf_nxt     = '0;
          bits_nxt    = '0;
          k_ctl.start = 1'b1;
          state_nxt   = S_JUDGE;
        end else if (bits_left < BITS_W'(4)) begin
          state_nxt = S_IDLE;
        end
      end
      S_JUDGE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign inc_bin = LVL_W'(inc_len - 4'd1);

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    verdict_nxt   = verdict_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      verdict_nxt   = k_sts.verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hdr_r       <= 1'b0;
      idx_r       <= '0;
      await_r     <= 1'b0;
      done_r      <= 1'b1;
      bits_r      <= '0;
      buf_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hdr_r       <= hdr_nxt;
      idx_r       <= idx_nxt;
      await_r     <= await_nxt;
      done_r      <= done_nxt;
      bits_r      <= bits_nxt;
      buf_r       <= buf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
  end

  // length histogram, cleared as a whole at block start
  always_ff @(posedge clk) begin
    if (!rst_n || hist_clr) begin
      for (int i = 0; i < MAX_LEN; i++) begin
        hist_r[i] <= '0;
      end
    end else if (inc_en) begin
      hist_r[inc_bin] <= hist_r[inc_bin] + CNT_W'(1);
    end
  end

  rar3hc_kraft u_kraft (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (k_ctl),
    .level_count (hist_r[k_sts.level]),
    .sts         (k_sts)
  );

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

endmodule

// ===== verif/rar3_huffman_table_check_core_tb.sv =====
// ----------------------------------------------------------------------------
// rar3_huffman_table_check_core_tb
// Self-checking bench for the RAR3 pre-code bit-length table check.
// Byte requests are built from nibble streams (complete, incomplete,
// over-subscribed and empty tables, truncated blocks, raw noise), driven
// with bursty timing and checked against an in-bench table screener.
// ----------------------------------------------------------------------------
module rar3_huffman_table_check_core_tb;
  import rar3hc_pkg::*;

  typedef logic [3:0] nib_t;

  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       drain;   // hold this request back until all verdicts are in
  } byte_req_t;

  // DUT-facing signals, known from time zero
  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte   = 8'h00;
  logic       in_block_start = 1'b0;
  logic       out_valid;
  logic       out_ready      = 1'b1;
  logic [1:0] out_verdict;

  byte_req_t byte_q[$];     // requests still to be offered
  verdict_t  verdict_q[$];  // verdicts predicted, not yet seen
  int        n_fail = 0;

  rar3_huffman_table_check_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_block_start (in_block_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_verdict    (out_verdict)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Table screener: mirrors the block's decode of one byte at a time
  // --------------------------------------------------------------------------
  logic [15:0] scr_buf;
  logic [4:0]  scr_bits;
  logic        scr_hdr_done;
  logic [4:0]  scr_idx;
  logic        scr_esc;
  logic [4:0]  scr_hist [MAX_LEN];
  logic        scr_done = 1'b1;   // idle until the first block start

  function automatic verdict_t kraft_verdict();
    logic        any;
    logic [16:0] rem;
    any = 1'b0;
    for (int l = 0; l < MAX_LEN; l++)
      if (scr_hist[l] != 0) any = 1'b1;
    if (!any) return VERDICT_NONE;
    rem = 17'd1;
    for (int l = 0; l < MAX_LEN; l++) begin
      rem = rem << 1;
      if (rem < scr_hist[l]) return VERDICT_OVER;
      rem = rem - scr_hist[l];
    end
    return (rem != 0) ? VERDICT_INCOMPLETE : VERDICT_VALID;
  endfunction

  function automatic void add_length(input int len);
    if (len >= 1 && len <= MAX_LEN) scr_hist[len-1] = scr_hist[len-1] + 5'd1;
    scr_idx = scr_idx + 5'd1;
  endfunction

  task automatic screen_byte(input logic [7:0] b, input logic s,
                             output logic got, output verdict_t v);
    nib_t nib;
    int   run_end;
    got = 1'b0;
    v   = VERDICT_VALID;
    if (s) begin
      scr_buf      = '0;
      scr_bits     = '0;
      scr_hdr_done = 1'b0;
      scr_idx      = '0;
      scr_esc      = 1'b0;
      for (int l = 0; l < MAX_LEN; l++) scr_hist[l] = '0;
      scr_done     = 1'b0;
    end
    if (scr_done) return;
    scr_buf  = {scr_buf[7:0], b};
    scr_bits = scr_bits + 5'd8;
    if (!scr_hdr_done) begin
      scr_bits     = scr_bits - 5'(HDR_BITS);
      scr_hdr_done = 1'b1;
    end
    while (scr_bits >= 5'd4 && !got) begin
      nib      = 4'(scr_buf >> (scr_bits - 5'd4));
      scr_bits = scr_bits - 5'd4;
      scr_buf  = scr_buf & ((16'h1 << scr_bits) - 16'h1);
      if (scr_esc) begin
        scr_esc = 1'b0;
        if (nib == 4'd0) begin
          add_length(MAX_LEN);
        end else begin
          run_end = int'(scr_idx) + int'(nib) + 2;
          scr_idx = (run_end > TABLE_ENTRIES) ? 5'(TABLE_ENTRIES) : 5'(run_end);
        end
      end else if (nib == NIB_ESC) begin
        scr_esc = 1'b1;
      end else begin
        add_length(int'(nib));
      end
      // table full: verdict now, rest of this byte is dropped
      if (!scr_esc && scr_idx >= TABLE_ENTRIES) begin
        scr_done = 1'b1;
        scr_buf  = '0;
        scr_bits = '0;
        got      = 1'b1;
        v        = kraft_verdict();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps; a drain-marked request is
  // held back until every predicted verdict has arrived
  // --------------------------------------------------------------------------
  int        burst_left = 0;
  int        gap_left   = 0;
  byte_req_t drv_req;
  logic      drv_got;
  verdict_t  drv_v;
  logic      drv_valid;
  logic [7:0] drv_data;
  logic      drv_start;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_data_byte   <= 8'h00;
      in_block_start <= 1'b0;
    end else begin
      drv_valid = in_valid;
      drv_data  = in_data_byte;
      drv_start = in_block_start;
      if (in_valid && in_ready) begin
        screen_byte(in_data_byte, in_block_start, drv_got, drv_v);
        if (drv_got) verdict_q.push_back(drv_v);
        drv_valid = 1'b0;
      end
      if (!drv_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_q.size() != 0 &&
                     !(byte_q[0].drain && verdict_q.size() != 0)) begin
          drv_req   = byte_q.pop_front();
          drv_valid = 1'b1;
          drv_data  = drv_req.data;
          drv_start = drv_req.start;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid       <= drv_valid;
      in_data_byte   <= drv_data;
      in_block_start <= drv_start;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready pattern changes mode every so often; two long hold-offs
  // at fixed cycle counts let the block back up and stall its input
  // --------------------------------------------------------------------------
  int   rx_cycle = 0;
  int   rx_hold  = 0;
  int   rx_mode  = 0;
  int   rx_left  = 0;
  logic rx_rdy;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
    end else begin
      rx_cycle++;
      if (rx_hold > 0) begin
        rx_hold--;
        rx_rdy = 1'b0;
      end else if (rx_cycle == 600 || rx_cycle == 2500) begin
        rx_hold = 400;
        rx_rdy  = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
          0:       rx_rdy = 1'b1;
          1:       rx_rdy = 1'($urandom_range(0, 1));
          2:       rx_rdy = ($urandom_range(0, 9) != 0);
          default: rx_rdy = (rx_cycle % 5 != 0);
        endcase
      end
      out_ready <= rx_rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each verdict taken is checked against the oldest prediction
  // --------------------------------------------------------------------------
  verdict_t mon_exp;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict with none predicted: expected none, actual %0d",
                 $time, out_verdict);
        n_fail++;
      end else begin
        mon_exp = verdict_q.pop_front();
        if (out_verdict !== mon_exp) begin
          $display("%0t: verdict mismatch: expected %0d, actual %0d",
                   $time, mon_exp, out_verdict);
          n_fail++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  nib_t nib_q[$];
  int   tbl_len [TABLE_ENTRIES];

  task automatic push_byte(input logic [7:0] d, input logic s, input logic dr);
    byte_req_t r;
    r.data  = d;
    r.start = s;
    r.drain = dr;
    byte_q.push_back(r);
  endtask

  // Packs two header bits plus nib_q into bytes, random padding at the end.
  // keep = 0 sends every byte, otherwise only the first keep bytes.
  task automatic send_nibbles(input int keep, input logic dr, output int sent);
    logic       bits_q[$];
    logic [7:0] b;
    int         nb;
    repeat (HDR_BITS) bits_q.push_back(1'($urandom_range(0, 1)));
    foreach (nib_q[n])
      for (int k = 3; k >= 0; k--) bits_q.push_back(nib_q[n][k]);
    while (bits_q.size() % 8 != 0) bits_q.push_back(1'($urandom_range(0, 1)));
    nb = bits_q.size() / 8;
    if (keep > 0 && keep < nb) nb = keep;
    for (int i = 0; i < nb; i++) begin
      for (int k = 0; k < 8; k++) b[7-k] = bits_q[i*8+k];
      push_byte(b, i == 0, dr && i == 0);
    end
    nib_q.delete();
    sent = nb;
  endtask

  // Fills tbl_len according to the kind of table wanted
  task automatic make_table(input int kind);
    int codes[$];
    int target, tries, i, slot;
    for (int e = 0; e < TABLE_ENTRIES; e++) tbl_len[e] = 0;
    case (kind)
      0, 1, 2: begin
        // grow a complete prefix code by splitting leaves
        target = (kind == 2) ? $urandom_range(2, TABLE_ENTRIES - 1)
                             : $urandom_range(2, TABLE_ENTRIES);
        codes  = '{1, 1};
        tries  = 0;
        while (codes.size() < target && tries < 300) begin
          i = $urandom_range(0, codes.size() - 1);
          if (codes[i] < MAX_LEN) begin
            codes[i] = codes[i] + 1;
            codes.insert(i, codes[i]);
          end
          tries++;
        end
        if (kind == 1) codes.delete($urandom_range(0, codes.size() - 1));
        if (kind == 2) codes.push_back($urandom_range(1, MAX_LEN));
        foreach (codes[c]) begin
          slot = $urandom_range(0, TABLE_ENTRIES - 1);
          while (tbl_len[slot] != 0) slot = $urandom_range(0, TABLE_ENTRIES - 1);
          tbl_len[slot] = codes[c];
        end
      end
      3: ;  // empty table
      4: for (int e = 0; e < TABLE_ENTRIES; e++)
           tbl_len[e] = $urandom_range(0, 1) ? 0 : $urandom_range(1, MAX_LEN);
      default: for (int e = 0; e < TABLE_ENTRIES; e++)
           tbl_len[e] = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 6);
    endcase
  endtask

  // Turns tbl_len into nibbles; zero runs go either plain or escaped, and a
  // run that reaches the end may overshoot it
  task automatic encode_table();
    int i, z, c, lo;
    i = 0;
    while (i < TABLE_ENTRIES) begin
      if (tbl_len[i] == MAX_LEN) begin
        nib_q.push_back(NIB_ESC);
        nib_q.push_back(4'd0);
        i++;
      end else if (tbl_len[i] != 0) begin
        nib_q.push_back(4'(tbl_len[i]));
        i++;
      end else begin
        z = 0;
        while (i + z < TABLE_ENTRIES && tbl_len[i+z] == 0) z++;
        if (z >= 3 && $urandom_range(0, 3) != 0) begin
          if (i + z == TABLE_ENTRIES && $urandom_range(0, 1)) begin
            lo = (z - 2 > 15) ? 15 : z - 2;
            c  = $urandom_range(lo, 15);
          end else begin
            c = $urandom_range(1, ((z > 17) ? 17 : z) - 2);
          end
          nib_q.push_back(NIB_ESC);
          nib_q.push_back(4'(c));
          i = (i + c + 2 > TABLE_ENTRIES) ? TABLE_ENTRIES : i + c + 2;
        end else begin
          nib_q.push_back(4'd0);
          i++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int sent, n_items, pick, n;

    // idle after reset: no block start yet, both bytes are ignored
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    // empty table: 17 + 3 zeros
    nib_q = '{NIB_ESC, NIB_ESC, NIB_ESC, 4'd1};
    send_nibbles(0, 1'b0, sent);
    // complete code: two length-1 codes, then 18 zeros
    nib_q = '{4'd1, 4'd1, NIB_ESC, NIB_ESC, 4'd0};
    send_nibbles(0, 1'b0, sent);
    // over-subscribed, with the largest plain length nibble
    nib_q = '{4'd1, 4'd1, 4'd14, NIB_ESC, NIB_ESC};
    send_nibbles(0, 1'b0, sent);
    // incomplete
    nib_q = '{4'd1, NIB_ESC, NIB_ESC, 4'd0, 4'd0};
    send_nibbles(0, 1'b0, sent);
    // escape on the last entry still waits for its count: one length 15
    nib_q = '{NIB_ESC, NIB_ESC, 4'd0, 4'd0, NIB_ESC, 4'd0};
    send_nibbles(0, 1'b0, sent);
    // zero run overshooting the end is clipped
    nib_q = '{4'd1, 4'd1, NIB_ESC, NIB_ESC, NIB_ESC, NIB_ESC};
    send_nibbles(0, 1'b0, sent);

    n_items = 0;
    while (n_items < 1100) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        n = $urandom_range(0, 99);
        make_table((n < 25) ? 0 : (n < 45) ? 1 : (n < 65) ? 2 :
                   (n < 70) ? 3 : (n < 85) ? 4 : 5);
        encode_table();
        // first random block waits for the pipe to empty, then now and again
        send_nibbles((pick < 70) ? 0 : $urandom_range(1, 4),
                     n_items == 0 || $urandom_range(0, 32) == 0, sent);
        n_items += sent;
        // trailing bytes after a verdict are dropped by the block
        if (pick < 70) repeat ($urandom_range(0, 2))
          push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else if (pick < 92) begin
        n = $urandom_range(3, 10);
        for (int k = 0; k < n; k++)
          push_byte(8'($urandom_range(0, 255)),
                    k == 0 || $urandom_range(0, 5) == 0, 1'b0);
        n_items += n;
      end else begin
        repeat ($urandom_range(1, 4))
          push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
